// ===== hdl/lsp_pkg.sv =====
// Shared constants, types and helper function of the lagged-subtract byte generator.
package lsp_pkg;

  localparam int WORD_W       = 16;
  localparam int BYTE_W       = 8;
  localparam int TBL_LEN      = 31;
  localparam int TBL_AW       = $clog2(TBL_LEN);
  localparam int TBL_SW       = TBL_AW + 1;
  localparam int TBL_MOD      = 65257;
  localparam int NEAR_LAG     = 10;
  localparam int FAR_LAG      = 20;
  localparam int WARMUP_STEPS = 256;
  localparam int CNT_W        = $clog2(WARMUP_STEPS + 2);

  // old_word / 255 for any 16-bit word: multiply by reciprocal, shift right.
  localparam logic [WORD_W-1:0] DIV255_MAGIC = 16'd32897;
  localparam int                DIV255_SHIFT = 23;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_GEN   = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TBL_AW-1:0] tbl_addr_t;

  typedef struct packed {
    logic      en;
    tbl_addr_t addr;
    word_t     data;
  } tbl_wr_t;

  typedef struct packed {
    word_t cur;
    word_t near_val;
    word_t far_val;
    word_t run;
    word_t rot;
  } step_in_t;

  typedef struct packed {
    word_t run;
    word_t rot;
    word_t mix;
    word_t upd;
  } step_out_t;

  // (pos + lag) mod TBL_LEN for pos below TBL_LEN and lag below TBL_LEN.
  function automatic tbl_addr_t lag_pos(input tbl_addr_t pos, input int lag);
    logic [TBL_SW-1:0] sum;
    sum = TBL_SW'(pos) + TBL_SW'(lag);
    if (sum >= TBL_SW'(TBL_LEN)) begin
      sum = sum - TBL_SW'(TBL_LEN);
    end
    return sum[TBL_AW-1:0];
  endfunction

endpackage

// ===== hdl/lsp_if.sv =====
// Valid/ready channel interfaces for the input words and the result bytes.
interface lsp_in_if import lsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TBL_AW-1:0] entry_index;
  logic [WORD_W-1:0] entry_value;

  modport source(output valid, output operation, output entry_index, output entry_value,
                 input ready);
  modport sink(input valid, input operation, input entry_index, input entry_value,
               output ready);
endinterface

interface lsp_out_if import lsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] random_byte;

  modport source(output valid, output random_byte, input ready);
  modport sink(input valid, input random_byte, output ready);
endinterface

// ===== hdl/lagged_subtract_prng_mod_65257.sv =====
// Top level of the lagged-subtract pseudorandom byte generator, modulus 65257.
//
// Lagged-subtract byte generator over a 31-entry table of 16-bit words. Input
// words carry an operation: load writes one table entry (seed values of 0 or
// at least 65257, and indexes above 30, are dropped), start clears the running
// sums and position and runs 256 warm-up steps, generate runs one step and
// returns one byte. Unused operation codes are dropped. Only generate returns
// a result byte. After reset the table holds k+1 in entry k. Each generator
// step runs through the states S_RD_CN, S_RD_F and S_EXE, set by the table
// memory: the step needs three table words (current, near lag, far lag) from
// a two-port memory with registered read data, so two read states come before
// the execute state, which writes the updated entry back. A generate word thus
// occupies the block for one step, a start word for 256 steps. in_ch.ready is
// high only while the sequencer is idle. The result sits in an output register;
// a new word is accepted while it waits, and a following generate holds in its
// execute state until the previous byte is taken.
module lagged_subtract_prng_mod_65257 import lsp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  lsp_in_if.sink    in_ch,
  lsp_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD_CN = 4'b0010,
    S_RD_F  = 4'b0100,
    S_EXE   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  tbl_addr_t         pos_r, pos_nxt;
  word_t             run_r, run_nxt;
  word_t             rot_r, rot_nxt;
  word_t             mix_r, mix_nxt;
  word_t             cur_r, cur_nxt;
  word_t             near_r, near_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              gen_r, gen_nxt;
  logic [BYTE_W-1:0] oldq_r, oldq_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;

  logic              in_acc;
  logic              load_ok;
  logic              commit;
  logic [2*WORD_W-1:0] div_prod;
  tbl_addr_t         near_pos;
  tbl_addr_t         far_pos;
  tbl_addr_t         raddr_a;
  tbl_wr_t           tbl_wr;
  word_t             rdata_a;
  word_t             rdata_b;
  step_in_t          step_in;
  step_out_t         step_out;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.random_byte = out_byte_r;

  // Seed words outside 1..65256 and indexes past the table end are dropped.
  assign load_ok = in_acc && (in_ch.operation == OP_LOAD)
                   && (in_ch.entry_index < TBL_AW'(TBL_LEN))
                   && (in_ch.entry_value != '0)
                   && (in_ch.entry_value < WORD_W'(TBL_MOD));

  // A generate step must find the output register free before it commits.
  assign commit = (state_r == S_EXE) && (!gen_r || !out_valid_r || out_ch.ready);

  assign near_pos = lag_pos(pos_r, NEAR_LAG);
  assign far_pos  = lag_pos(pos_r, FAR_LAG);
  // Port A fetches the current entry first, then the far-lag entry; keep the
  // far address up through execute so a stalled step sees stable data.
  assign raddr_a  = (state_r == S_RD_CN) ? pos_r : far_pos;

  always_comb begin
    tbl_wr.en   = load_ok || commit;
    tbl_wr.addr = (state_r == S_EXE) ? pos_r : in_ch.entry_index;
    tbl_wr.data = (state_r == S_EXE) ? step_out.upd : in_ch.entry_value;
  end

  lsp_table_ram u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (tbl_wr),
    .raddr_a (raddr_a),
    .raddr_b (near_pos),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_comb begin
    step_in.cur      = cur_r;
    step_in.near_val = near_r;
    step_in.far_val  = rdata_a;
    step_in.run      = run_r;
    step_in.rot      = rot_r;
  end

  lsp_step_unit u_step (
    .si (step_in),
    .so (step_out)
  );

  // Old mixed word divided by 255; only the low byte reaches the result.
  assign div_prod = (2*WORD_W)'(mix_r) * (2*WORD_W)'(DIV255_MAGIC);

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    run_nxt       = run_r;
    rot_nxt       = rot_r;
    mix_nxt       = mix_r;
    cur_nxt       = cur_r;
    near_nxt      = near_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    oldq_nxt      = oldq_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.operation == OP_START)) begin
          run_nxt = '0;
          rot_nxt = '0;
          pos_nxt = '0;
          gen_nxt = 1'b0;
          cnt_nxt = CNT_W'(WARMUP_STEPS);
          if (WARMUP_STEPS != 0) begin
            state_nxt = S_RD_CN;
          end
        end else if (in_acc && (in_ch.operation == OP_GEN)) begin
          gen_nxt   = 1'b1;
          oldq_nxt  = div_prod[DIV255_SHIFT +: BYTE_W];
          state_nxt = S_RD_CN;
        end
      end
      S_RD_CN: begin
        state_nxt = S_RD_F;
      end
      S_RD_F: begin
        // Capture current and near-lag words; far-lag word lands next cycle.
        cur_nxt   = rdata_a;
        near_nxt  = rdata_b;
        state_nxt = S_EXE;
      end
      S_EXE: begin
        if (commit) begin
          run_nxt = step_out.run;
          rot_nxt = step_out.rot;
          mix_nxt = step_out.mix;
          pos_nxt = lag_pos(pos_r, 1);
          if (gen_r) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = step_out.mix[BYTE_W-1:0] + oldq_r;
            state_nxt     = S_IDLE;
          end else if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_RD_CN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      run_r       <= '0;
      rot_r       <= '0;
      mix_r       <= '0;
      cnt_r       <= '0;
      gen_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      run_r       <= run_nxt;
      rot_r       <= rot_nxt;
      mix_r       <= mix_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    near_r     <= near_nxt;
    oldq_r     <= oldq_nxt;
    out_byte_r <= out_byte_nxt;
  end

endmodule

// ===== hdl/lsp_table_ram.sv =====
// Lag table memory: one write port, two registered read ports, per-entry valid bits.
module lsp_table_ram import lsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tbl_wr_t   wr,
  input  tbl_addr_t raddr_a,
  input  tbl_addr_t raddr_b,
  output word_t     rdata_a,
  output word_t     rdata_b
);

  word_t              mem_r [TBL_LEN];
  logic [TBL_LEN-1:0] vld_r;
  word_t              rd_a_r;
  word_t              rd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Unwritten entries read as their seed default, index plus one.
  always_ff @(posedge clk) begin
    rd_a_r <= vld_r[raddr_a] ? mem_r[raddr_a] : WORD_W'(raddr_a) + WORD_W'(1);
    rd_b_r <= vld_r[raddr_b] ? mem_r[raddr_b] : WORD_W'(raddr_b) + WORD_W'(1);
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// ===== hdl/lsp_step_unit.sv =====
// Arithmetic of one generator step: sums, rotate, mix and modular table update.
module lsp_step_unit import lsp_pkg::*; (
  input  step_in_t  si,
  output step_out_t so
);

  word_t             run_new;
  word_t             rot_new;
  logic [WORD_W:0]   wrap_sum;

  assign run_new  = si.run + si.cur;
  assign rot_new  = {si.rot[0], si.rot[WORD_W-1:1]} + si.far_val;
  assign wrap_sum = (WORD_W+1)'(si.cur) + (WORD_W+1)'(TBL_MOD) - (WORD_W+1)'(si.near_val);

  assign so.run = run_new;
  assign so.rot = rot_new;
  assign so.mix = run_new ^ rot_new;
  // Wrap the difference into the modulus when it would go negative.
  assign so.upd = (si.cur >= si.near_val) ? (si.cur - si.near_val) : wrap_sum[WORD_W-1:0];

endmodule
